// ----- sv/sws_pkg.sv -----
// shared types and constants for the shell word splitter
// no dependencies

`default_nettype none

package sws_pkg;

    // slot ceiling of the build; the word counter never goes past 255 words
    localparam int MAX_SLOTS = 256;
    localparam logic [8:0] SLOT_CAP = (MAX_SLOTS > 256) ? 9'd256 : 9'(MAX_SLOTS);

    localparam logic [8:0] ARG_SLOTS_RESET = 9'd32;

    // register index of arg_slots
    localparam logic REG_ARG_SLOTS = 1'b0;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_BARE   = 2'd1,
        MODE_QUOTED = 2'd2,
        MODE_SKIP   = 2'd3
    } mode_t;

endpackage

`default_nettype wire

// ----- sv/shell_word_splitter_top.sv -----
// shell word splitter: one line byte in, one word event beat out
// depends on sws_pkg
// latency: the result beat for a byte is valid the cycle after the byte is accepted
// throughput: one byte per cycle while out_ready keeps up; scan state updates at the
//   accept edge, the result sits in one output register refilled as it is taken
// reset (rst_n low, async): between words, word count 0, arg_slots 32, no beat out

`default_nettype none

module shell_word_splitter_top
    import sws_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [7:0]  data_byte,
    output logic             data_valid,
    output logic             token_open,
    output logic             token_close,
    output logic      [7:0]  token_index,
    output logic             finished,
    output logic             overflow_error,
    output logic      [7:0]  token_count
);

    logic [8:0] arg_slots_reg;
    mode_t      mode_reg, mode_next;
    logic [7:0] quote_reg, quote_next;
    logic       esc_reg, esc_next;
    logic [7:0] word_cnt_reg, word_cnt_next;

    logic       out_valid_reg;
    logic [7:0] data_byte_reg, data_byte_next;
    logic       data_valid_reg, data_valid_next;
    logic       open_reg, open_next;
    logic       close_reg, close_next;
    logic [7:0] index_reg, index_next;
    logic       fin_reg, fin_next;
    logic       ovf_reg, ovf_next;
    logic [7:0] count_reg, count_next;

    logic       in_accept;
    logic       cfg_write;
    logic [8:0] slot_lim;
    logic       may_open;
    logic [7:0] cur_word;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_ARG_SLOTS) ? {23'd0, arg_slots_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arg_slots_reg <= ARG_SLOTS_RESET;
        end
        else if (cfg_write && paddr[2] == REG_ARG_SLOTS)
        begin
            arg_slots_reg <= pwdata[8:0];
        end
    end

    // output register frees up in the same cycle its beat is taken
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    assign slot_lim = (arg_slots_reg > SLOT_CAP) ? SLOT_CAP : arg_slots_reg;
    assign may_open = ({1'b0, word_cnt_reg} + 9'd1) < slot_lim;
    assign cur_word = (word_cnt_reg != 8'd0) ? word_cnt_reg - 8'd1 : 8'd0;

    always_comb
    begin
        mode_next       = mode_reg;
        quote_next      = quote_reg;
        esc_next        = esc_reg;
        word_cnt_next   = word_cnt_reg;
        data_byte_next  = 8'd0;
        data_valid_next = 1'b0;
        open_next       = 1'b0;
        close_next      = 1'b0;
        index_next      = 8'd0;
        fin_next        = 1'b0;
        ovf_next        = 1'b0;
        count_next      = 8'd0;

        if (in_byte == CH_NUL)
        begin
            fin_next = 1'b1;
            if (mode_reg == MODE_SKIP)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                if (mode_reg == MODE_BARE || mode_reg == MODE_QUOTED)
                begin
                    close_next = 1'b1;
                    index_next = cur_word;
                end
                count_next = word_cnt_reg;
            end
            mode_next     = MODE_IDLE;
            quote_next    = 8'd0;
            esc_next      = 1'b0;
            word_cnt_next = 8'd0;
        end
        else
        begin
            case (mode_reg)
                MODE_SKIP:
                begin
                    ovf_next = 1'b1;
                end
                MODE_QUOTED:
                begin
                    index_next = cur_word;
                    if (in_byte == quote_reg)
                    begin
                        close_next = 1'b1;
                        mode_next  = MODE_IDLE;
                    end
                    else
                    begin
                        data_valid_next = 1'b1;
                        data_byte_next  = in_byte;
                    end
                end
                MODE_BARE:
                begin
                    index_next = cur_word;
                    if (esc_reg)
                    begin
                        esc_next        = 1'b0;
                        data_valid_next = 1'b1;
                        data_byte_next  = in_byte;
                    end
                    else if (in_byte inside {CH_SPACE, CH_TAB})
                    begin
                        close_next = 1'b1;
                        mode_next  = MODE_IDLE;
                    end
                    else if (in_byte == CH_BACKSLASH)
                    begin
                        esc_next = 1'b1;
                    end
                    else
                    begin
                        data_valid_next = 1'b1;
                        data_byte_next  = in_byte;
                    end
                end
                default:
                begin
                    // between words
                    if (in_byte inside {CH_SPACE, CH_TAB})
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else if (!may_open)
                    begin
                        ovf_next  = 1'b1;
                        mode_next = MODE_SKIP;
                    end
                    else
                    begin
                        open_next     = 1'b1;
                        index_next    = word_cnt_reg;
                        word_cnt_next = word_cnt_reg + 8'd1;
                        if (in_byte inside {CH_SQUOTE, CH_DQUOTE})
                        begin
                            mode_next  = MODE_QUOTED;
                            quote_next = in_byte;
                        end
                        else
                        begin
                            mode_next = MODE_BARE;
                            if (in_byte == CH_BACKSLASH)
                            begin
                                esc_next = 1'b1;
                            end
                            else
                            begin
                                data_valid_next = 1'b1;
                                data_byte_next  = in_byte;
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            quote_reg     <= 8'd0;
            esc_reg       <= 1'b0;
            word_cnt_reg  <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                mode_reg     <= mode_next;
                quote_reg    <= quote_next;
                esc_reg      <= esc_next;
                word_cnt_reg <= word_cnt_next;
            end
            if (in_accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            data_byte_reg  <= data_byte_next;
            data_valid_reg <= data_valid_next;
            open_reg       <= open_next;
            close_reg      <= close_next;
            index_reg      <= index_next;
            fin_reg        <= fin_next;
            ovf_reg        <= ovf_next;
            count_reg      <= count_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign data_byte      = data_byte_reg;
    assign data_valid     = data_valid_reg;
    assign token_open     = open_reg;
    assign token_close    = close_reg;
    assign token_index    = index_reg;
    assign finished       = fin_reg;
    assign overflow_error = ovf_reg;
    assign token_count    = count_reg;

    // a count is only reported on a clean end of line
    a_count_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && count_reg != 8'd0 |-> fin_reg && !ovf_reg)
        else $error("token_count set outside a clean end of line");

    // opening a word never coincides with an error or the end
    a_open_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && open_reg |-> !ovf_reg && !fin_reg && index_reg == cur_word)
        else $error("bad word open beat");

    // the terminating byte returns the scanner to its idle state
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && in_byte == CH_NUL |=> mode_reg == MODE_IDLE && word_cnt_reg == 8'd0
            && !esc_reg)
        else $error("line state not cleared at end of line");

    // an accepted byte always lands in the output register
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted byte produced no result beat");

endmodule

`default_nettype wire

// ----- verif/tb_shell_word_splitter_top.sv -----
// testbench for shell_word_splitter_top: directed byte table, then random command lines
// over many arg_slots settings, each beat checked against a fixed row or local splitter
// depends on sws_pkg and shell_word_splitter_top

`timescale 1ns / 1ps

module tb_shell_word_splitter_top;
    import sws_pkg::*;

    localparam int ITEMS_GOAL = 700;
    // the limit leaves ample room for the slowest run: sparse receiver stalls
    // plus sender gaps, one long hold and every register phase
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD = 300;
    localparam int PRINT_CAP = 200;
    localparam logic [2:0] ARG_SLOTS_ADDR = 3'(REG_ARG_SLOTS) << 2;

    typedef struct packed {
        logic [7:0] dbyte;
        logic       dvalid;
        logic       topen;
        logic       tclose;
        logic [7:0] tidx;
        logic       fin;
        logic       ovf;
        logic [7:0] tcount;
    } word_event_t;

    typedef struct packed {
        logic [7:0]  b;
        logic        fixed;
        word_event_t ev;
    } line_beat_t;

    typedef enum int {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE,
        RDY_MOSTLY
    } stall_style_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        token_open;
    logic        token_close;
    logic [7:0]  token_index;
    logic        finished;
    logic        overflow_error;
    logic [7:0]  token_count;

    shell_word_splitter_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .data_byte      (data_byte),
        .data_valid     (data_valid),
        .token_open     (token_open),
        .token_close    (token_close),
        .token_index    (token_index),
        .finished       (finished),
        .overflow_error (overflow_error),
        .token_count    (token_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // local copy of the splitter state and its register
    logic [8:0] slots_cfg = ARG_SLOTS_RESET;
    mode_t      scan = MODE_IDLE;
    logic [7:0] quote_ch = '0;
    logic       esc_due = 1'b0;
    int         words = 0;

    line_beat_t  line_bytes[$];
    word_event_t due_events[$];
    int          queued_items = 0;
    int          errors = 0;
    int          holds_asked = 0;
    int          holds_done = 0;
    int          cycles = 0;
    line_beat_t  dir_rows [0:22];

    function automatic word_event_t split_step(input logic [7:0] b);
        word_event_t ev;
        logic [7:0]  cur;
        logic [8:0]  eff_slots;
        logic        in_word;
        ev = '0;
        in_word = (scan == MODE_BARE) || (scan == MODE_QUOTED);
        cur = (words != 0) ? 8'(words - 1) : 8'd0;
        eff_slots = (slots_cfg > SLOT_CAP) ? SLOT_CAP : slots_cfg;
        if (b == CH_NUL)
        begin
            ev.fin = 1'b1;
            if (scan == MODE_SKIP)
                ev.ovf = 1'b1;
            else
            begin
                if (in_word)
                begin
                    ev.tclose = 1'b1;
                    ev.tidx = cur;
                end
                ev.tcount = 8'(words);
            end
            scan = MODE_IDLE;
            quote_ch = '0;
            esc_due = 1'b0;
            words = 0;
        end
        else if (scan == MODE_SKIP)
            ev.ovf = 1'b1;
        else if (scan == MODE_QUOTED)
        begin
            ev.tidx = cur;
            if (b == quote_ch)
            begin
                ev.tclose = 1'b1;
                scan = MODE_IDLE;
            end
            else
            begin
                ev.dvalid = 1'b1;
                ev.dbyte = b;
            end
        end
        else if (scan == MODE_BARE)
        begin
            ev.tidx = cur;
            if (esc_due)
            begin
                esc_due = 1'b0;
                ev.dvalid = 1'b1;
                ev.dbyte = b;
            end
            else if (b == CH_SPACE || b == CH_TAB)
            begin
                ev.tclose = 1'b1;
                scan = MODE_IDLE;
            end
            else if (b == CH_BACKSLASH)
                esc_due = 1'b1;
            else
            begin
                ev.dvalid = 1'b1;
                ev.dbyte = b;
            end
        end
        else if (b == CH_SPACE || b == CH_TAB)
        begin
            // separator between words
        end
        else if (!(words + 1 < int'(eff_slots)))
        begin
            ev.ovf = 1'b1;
            scan = MODE_SKIP;
        end
        else
        begin
            ev.topen = 1'b1;
            ev.tidx = 8'(words);
            words++;
            if (b == CH_SQUOTE || b == CH_DQUOTE)
            begin
                scan = MODE_QUOTED;
                quote_ch = b;
            end
            else
            begin
                scan = MODE_BARE;
                if (b == CH_BACKSLASH)
                    esc_due = 1'b1;
                else
                begin
                    ev.dvalid = 1'b1;
                    ev.dbyte = b;
                end
            end
        end
        return ev;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        errors++;
        if (errors <= PRINT_CAP)
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
    endtask

    // sender: bursts of random length, random gaps in between
    int burst_left = 8;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        word_event_t pred;
        logic        take_next;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte <= '0;
        end
        else
        begin
            take_next = !(in_valid && !in_ready);
            if (in_valid && in_ready)
            begin
                pred = split_step(line_bytes[0].b);
                due_events.push_back(line_bytes[0].fixed ? line_bytes[0].ev : pred);
                void'(line_bytes.pop_front());
            end
            if (take_next)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (line_bytes.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_byte <= line_bytes[0].b;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        // now and then a stretch with no gaps at all
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall style changes at random intervals, plus a long hold on request
    stall_style_t style = RDY_ALWAYS;
    int style_left = 32;
    int hold_left = 0;
    int sparse_ct = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            style_left--;
            sparse_ct++;
            if (style_left <= 0)
            begin
                style = stall_style_t'($urandom_range(0, 3));
                style_left = $urandom_range(16, 96);
            end
            if (holds_done != holds_asked)
            begin
                holds_done++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (style)
                    RDY_ALWAYS: out_ready <= 1'b1;
                    RDY_COIN:   out_ready <= 1'($urandom_range(0, 1));
                    RDY_SPARSE: out_ready <= (sparse_ct % 4 == 0);
                    default:    out_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        word_event_t got;
        word_event_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{data_byte, data_valid, token_open, token_close, token_index,
                    finished, overflow_error, token_count};
            if (due_events.size() == 0)
            begin
                errors++;
                if (errors <= PRINT_CAP)
                    $display("%0t: result beat with nothing expected, got %0h", $time, got);
            end
            else
            begin
                want = due_events.pop_front();
                if (got.dbyte !== want.dbyte)
                    note_mismatch("data_byte", 32'(want.dbyte), 32'(got.dbyte));
                if (got.dvalid !== want.dvalid)
                    note_mismatch("data_valid", 32'(want.dvalid), 32'(got.dvalid));
                if (got.topen !== want.topen)
                    note_mismatch("token_open", 32'(want.topen), 32'(got.topen));
                if (got.tclose !== want.tclose)
                    note_mismatch("token_close", 32'(want.tclose), 32'(got.tclose));
                if (got.tidx !== want.tidx)
                    note_mismatch("token_index", 32'(want.tidx), 32'(got.tidx));
                if (got.fin !== want.fin)
                    note_mismatch("finished", 32'(want.fin), 32'(got.fin));
                if (got.ovf !== want.ovf)
                    note_mismatch("overflow_error", 32'(want.ovf), 32'(got.ovf));
                if (got.tcount !== want.tcount)
                    note_mismatch("token_count", 32'(want.tcount), 32'(got.tcount));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic apb_xfer(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= ARG_SLOTS_ADDR;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
            @(negedge clk);
        rdata = prdata;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        while (line_bytes.size() != 0 || in_valid || due_events.size() != 0)
            @(posedge clk);
        // a little margin after the last result beat
        repeat (3) @(posedge clk);
    endtask

    task automatic set_slots(input logic [8:0] v);
        logic [31:0] rd;
        wait_drained();
        apb_xfer(1'b1, {23'($urandom()), v}, rd);
        slots_cfg = v;
        apb_xfer(1'b0, '0, rd);
        if (rd !== {23'd0, v})
            note_mismatch("arg_slots readback", {23'd0, v}, rd);
    endtask

    task automatic queue_beat(input logic [7:0] b);
        line_bytes.push_back('{b, 1'b0, '0});
        queued_items++;
    endtask

    function automatic logic [7:0] sep_char();
        return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
    endfunction

    function automatic logic [7:0] odd_char();
        case ($urandom_range(0, 4))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_DQUOTE;
            3:       return CH_SQUOTE;
            default: return CH_BACKSLASH;
        endcase
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
        begin
            if ($urandom_range(0, 9) == 0)
                c = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
            else if ($urandom_range(0, 2) == 0)
                c = 8'($urandom_range(1, 255));
            else
                c = 8'($urandom_range(8'h21, 8'h7e));
        end
        while (c == CH_SPACE || c == CH_TAB || c == CH_BACKSLASH);
        return c;
    endfunction

    task automatic queue_line(input int n_words, input logic terminate);
        int         k;
        int         len;
        logic [7:0] q;
        logic [7:0] c;
        logic       quoted_prev;
        quoted_prev = 1'b0;
        if ($urandom_range(0, 2) == 0)
            queue_beat(sep_char());
        for (k = 0; k < n_words; k++)
        begin
            // a closing quote ends a word, so the next one may follow directly
            if (k > 0 && !(quoted_prev && $urandom_range(0, 2) == 0))
            begin
                queue_beat(sep_char());
                if ($urandom_range(0, 3) == 0)
                    queue_beat(sep_char());
            end
            len = $urandom_range(0, 5);
            if ($urandom_range(0, 3) == 0)
            begin
                q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
                queue_beat(q);
                repeat (len)
                begin
                    do
                        c = ($urandom_range(0, 3) == 0) ? odd_char()
                                                        : 8'($urandom_range(1, 255));
                    while (c == q);
                    queue_beat(c);
                end
                if ($urandom_range(0, 9) != 0)
                    queue_beat(q);
                quoted_prev = 1'b1;
            end
            else
            begin
                repeat (len + 1)
                begin
                    if ($urandom_range(0, 5) == 0)
                    begin
                        queue_beat(CH_BACKSLASH);
                        queue_beat(($urandom_range(0, 1)) ? odd_char()
                                                          : 8'($urandom_range(0, 255)));
                    end
                    else
                        queue_beat(plain_char());
                end
                quoted_prev = 1'b0;
            end
        end
        if ($urandom_range(0, 3) == 0)
            queue_beat(sep_char());
        if (terminate)
            queue_beat(CH_NUL);
    endtask

    task automatic queue_noise_line();
        repeat ($urandom_range(1, 14))
            queue_beat($urandom_range(0, 1) ? odd_char() : 8'($urandom_range(1, 255)));
        queue_beat(CH_NUL);
    endtask

    // one line of many one-letter words
    task automatic queue_many_words(input int count);
        repeat (count)
        begin
            queue_beat(8'($urandom_range(8'h61, 8'h7a)));
            queue_beat(CH_SPACE);
        end
        queue_beat(CH_NUL);
    endtask

    task automatic queue_phase(input logic [8:0] v);
        int n_lines;
        int k;
        set_slots(v);
        n_lines = $urandom_range(3, 6);
        for (k = 0; k < n_lines; k++)
        begin
            if ($urandom_range(0, 7) == 0)
                queue_noise_line();
            else
                // last line sometimes left open across the next register write
                queue_line($urandom_range(0, 7),
                           (k != n_lines - 1) || ($urandom_range(0, 4) != 0));
        end
    endtask

    initial
    begin
        int          i;
        logic [31:0] rd;
        logic [8:0]  corner_slots [6];
        corner_slots = '{9'd1, 9'd0, 9'd2, 9'd3, 9'd256, 9'd511};

        dir_rows = '{
            '{CH_NUL,    1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 8'd0, 1'b1, 1'b0, 8'd0}},
            '{CH_SPACE,  1'b1, '0},
            '{CH_TAB,    1'b1, '0},
            '{8'h61,     1'b1, '{8'h61, 1'b1, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0}},
            '{CH_BACKSLASH, 1'b0, '0},
            '{CH_SPACE,  1'b0, '0},   // escaped separator is data
            '{CH_DQUOTE, 1'b0, '0},   // quote inside a bare word is data
            '{CH_TAB,    1'b0, '0},
            '{CH_DQUOTE, 1'b0, '0},
            '{CH_DQUOTE, 1'b0, '0},   // empty quoted word
            '{CH_SQUOTE, 1'b0, '0},
            '{CH_BACKSLASH, 1'b0, '0},
            '{CH_SPACE,  1'b0, '0},
            '{CH_DQUOTE, 1'b0, '0},
            '{8'hff,     1'b0, '0},
            '{8'h01,     1'b0, '0},
            '{CH_SQUOTE, 1'b0, '0},
            '{8'h7e,     1'b0, '0},   // new word right after the closing quote
            '{CH_BACKSLASH, 1'b0, '0},
            '{CH_NUL,    1'b0, '0},   // end right after a backslash
            '{CH_DQUOTE, 1'b0, '0},
            '{8'h80,     1'b0, '0},
            '{CH_NUL,    1'b0, '0}    // end inside an open quote
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        apb_xfer(1'b0, '0, rd);
        if (rd !== 32'(ARG_SLOTS_RESET))
            note_mismatch("arg_slots after reset", 32'(ARG_SLOTS_RESET), rd);

        for (i = 0; i < 23; i++)
            line_bytes.push_back(dir_rows[i]);
        queued_items = 0;

        foreach (corner_slots[i])
        begin
            queue_phase(corner_slots[i]);
            if (corner_slots[i] == 9'd511)
            begin
                // receiver holds off while a line past the 255-word ceiling keeps coming
                holds_asked++;
                queue_many_words(256);
            end
        end

        while (queued_items < ITEMS_GOAL)
            queue_phase(($urandom_range(0, 9) < 7) ? 9'($urandom_range(2, 8))
                                                    : 9'($urandom_range(0, 511)));
        queue_beat(CH_NUL);

        wait_drained();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/sws_pkg.sv
sv/shell_word_splitter_top.sv
verif/tb_shell_word_splitter_top.sv
